FILE: rtl/icg_pkg.sv
package icg_pkg;

   // Default storage geometry
   localparam int ICG_TABLE_DEPTH = 1024;
   localparam int ICG_VALUE_WIDTH = 32;

   // Fixed field widths
   localparam int ICG_OP_WIDTH     = 2;
   localparam int ICG_POS_WIDTH    = 10;
   localparam int ICG_ID_WIDTH     = 32;
   localparam int ICG_COUNT_WIDTH  = 11;
   localparam int ICG_CSR_IDX_WIDTH = 3;
   localparam int ICG_CSR_WIDTH    = 32;
   localparam int ICG_REQ_DATA_WIDTH = 80;
   localparam int ICG_RSP_USER_WIDTH = 3;

   // Request operation codes
   typedef enum logic [ICG_OP_WIDTH-1:0] {
      OP_LOAD    = 2'd0,
      OP_PROJECT = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } icg_op_type;

   // Configuration register indexes
   typedef enum logic [ICG_CSR_IDX_WIDTH-1:0] {
      CSR_RIGHT_BASE     = 3'd0,
      CSR_RIGHT_COUNT    = 3'd1,
      CSR_DENSE_MODE     = 3'd2,
      CSR_DENSE_START    = 3'd3,
      CSR_CHECK_NILS     = 3'd4,
      CSR_VALUE_NIL_CODE = 3'd5,
      CSR_INDEX_NIL_CODE = 3'd6,
      CSR_RESERVED       = 3'd7
   } icg_csr_type;

   // Settings the result stage needs
   typedef struct packed {
      logic                       dense_mode;
      logic                       check_nils;
      logic [ICG_VALUE_WIDTH-1:0] dense_start;
      logic [ICG_VALUE_WIDTH-1:0] value_nil_code;
   } icg_cfg_type;

   // Lookup outcome carried from the front end to the result stage
   typedef struct packed {
      logic in_range;
      logic id_nil;
   } icg_ctrl_type;

endpackage

FILE: rtl/indexed_column_gather_unit.sv
// Pipeline: an accepted project transaction passes the table read register and
// then the result register before it shows on rsp.
// Throughput: one transaction per cycle while rsp_tready stays high; the
// single table read port and the result register set that figure.
// Reset: synchronous; clears the pipeline, the sticky nil flag and the
// registers to their defaults. The table is not cleared and needs loading.
module indexed_column_gather_unit #(
   parameter int TABLE_DEPTH = icg_pkg::ICG_TABLE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Configuration write port
   input  logic                                   csr_we,
   input  logic [icg_pkg::ICG_CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [icg_pkg::ICG_CSR_WIDTH-1:0]      csr_wdata,
   // Request stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: load_position[9:0], load_value[41:10], row_id[73:42], zero[79:74]
   input  logic [icg_pkg::ICG_REQ_DATA_WIDTH-1:0] req_tdata,
   // tuser: operation[1:0]
   input  logic [icg_pkg::ICG_OP_WIDTH-1:0]       req_tuser,
   // Response stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata: value[31:0]
   output logic [icg_pkg::ICG_VALUE_WIDTH-1:0]    rsp_tdata,
   // tuser: value_is_nil[0], no_match[1], column_has_nil[2]
   output logic [icg_pkg::ICG_RSP_USER_WIDTH-1:0] rsp_tuser
);

   import icg_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [ICG_ID_WIDTH-1:0]    right_base_ff;
   logic [ICG_COUNT_WIDTH-1:0] right_count_ff;
   logic                       dense_mode_ff;
   logic [ICG_VALUE_WIDTH-1:0] dense_start_ff;
   logic                       check_nils_ff;
   logic [ICG_VALUE_WIDTH-1:0] value_nil_code_ff;
   logic [ICG_ID_WIDTH-1:0]    index_nil_code_ff;

   icg_op_type                 op;
   logic [ICG_POS_WIDTH-1:0]   load_position;
   logic [ICG_VALUE_WIDTH-1:0] load_value;
   logic [ICG_ID_WIDTH-1:0]    row_id;
   logic                       accept;
   logic                       free;
   logic [ICG_ID_WIDTH:0]      diff;
   logic [31:0]                eff_count;
   logic [31:0]                pos_wide;
   icg_ctrl_type               ctrl;
   logic [AW-1:0]              offset;
   logic [AW-1:0]              load_addr;
   logic                       wr_en;
   logic                       rd_en;
   logic                       restart;
   icg_cfg_type                cfg;
   logic [ICG_VALUE_WIDTH-1:0] rd_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         right_base_ff     <= '0;
         right_count_ff    <= '0;
         dense_mode_ff     <= 1'b0;
         dense_start_ff    <= '0;
         check_nils_ff     <= 1'b1;
         value_nil_code_ff <= 32'h8000_0000;
         index_nil_code_ff <= 32'h8000_0000;
      end else if (csr_we) begin
         case (icg_csr_type'(csr_index))
            CSR_RIGHT_BASE:     right_base_ff     <= csr_wdata;
            CSR_RIGHT_COUNT:    right_count_ff    <= csr_wdata[ICG_COUNT_WIDTH-1:0];
            CSR_DENSE_MODE:     dense_mode_ff     <= csr_wdata[0];
            CSR_DENSE_START:    dense_start_ff    <= csr_wdata;
            CSR_CHECK_NILS:     check_nils_ff     <= csr_wdata[0];
            CSR_VALUE_NIL_CODE: value_nil_code_ff <= csr_wdata;
            CSR_INDEX_NIL_CODE: index_nil_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the request
   assign op            = icg_op_type'(req_tuser);
   assign load_position = req_tdata[9:0];
   assign load_value    = req_tdata[41:10];
   assign row_id        = req_tdata[73:42];

   assign req_tready = free;
   assign accept     = req_tvalid && free;

   // Range test against the saturated count
   assign eff_count = ({21'b0, right_count_ff} > 32'(TABLE_DEPTH))
                    ? 32'(TABLE_DEPTH) : {21'b0, right_count_ff};
   assign diff   = {1'b0, row_id} - {1'b0, right_base_ff};
   assign offset = diff[AW-1:0];

   always_comb begin
      ctrl.in_range = !diff[ICG_ID_WIDTH] && (diff[ICG_ID_WIDTH-1:0] < eff_count);
      ctrl.id_nil   = (row_id == index_nil_code_ff);
   end

   // Table access: loads write, projects read
   assign pos_wide  = {{(32-ICG_POS_WIDTH){1'b0}}, load_position};
   assign load_addr = pos_wide[AW-1:0];
   assign wr_en     = accept && (op == OP_LOAD) && (pos_wide < 32'(TABLE_DEPTH));
   assign rd_en     = accept && (op == OP_PROJECT);
   assign restart   = accept && (op == OP_RESTART);

   icg_ram #(
      .WIDTH (ICG_VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_addr),
      .wr_data (load_value),
      .rd_en   (rd_en),
      .rd_addr (offset),
      .rd_data (rd_data)
   );

   always_comb begin
      cfg.dense_mode     = dense_mode_ff;
      cfg.check_nils     = check_nils_ff;
      cfg.dense_start    = dense_start_ff;
      cfg.value_nil_code = value_nil_code_ff;
   end

   icg_resolve #(
      .AW (AW)
   ) u_resolve (
      .clock        (clock),
      .reset        (reset),
      .issue        (rd_en),
      .issue_ctrl   (ctrl),
      .issue_offset (offset),
      .restart      (restart),
      .cfg          (cfg),
      .rd_data      (rd_data),
      .free         (free),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_value    (rsp_tdata),
      .rsp_flags    (rsp_tuser)
   );

endmodule

FILE: rtl/icg_ram.sv
module icg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/icg_resolve.sv
module icg_resolve #(
   parameter int AW = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                issue,
   input  icg_pkg::icg_ctrl_type               issue_ctrl,
   input  logic [AW-1:0]                       issue_offset,
   input  logic                                restart,
   input  icg_pkg::icg_cfg_type                cfg,
   input  logic [icg_pkg::ICG_VALUE_WIDTH-1:0] rd_data,
   output logic                                free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [icg_pkg::ICG_VALUE_WIDTH-1:0] rsp_value,
   output logic [icg_pkg::ICG_RSP_USER_WIDTH-1:0] rsp_flags
);

   import icg_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   icg_ctrl_type               s1_ctrl_ff;
   logic [AW-1:0]              s1_offset_ff;
   logic                       nil_seen_ff, nil_seen_in;
   logic                       out_valid_ff, out_valid_in;
   logic [ICG_VALUE_WIDTH-1:0] out_value_ff;
   logic [ICG_RSP_USER_WIDTH-1:0] out_flags_ff;
   logic                       advance;
   logic [ICG_VALUE_WIDTH-1:0] dense_value;
   logic [ICG_VALUE_WIDTH-1:0] res_value;
   logic                       res_nil;
   logic                       res_miss;
   logic                       res_sticky;

   // Move the lookup into the output register when it is empty or drained
   assign advance = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign free    = !s1_valid_ff || advance;

   assign dense_value = cfg.dense_start
                      + {{(ICG_VALUE_WIDTH-AW){1'b0}}, s1_offset_ff};

   // Resolve value and flags from the fetched entry
   always_comb begin
      res_value = '0;
      res_nil   = 1'b0;
      res_miss  = 1'b0;
      if (s1_ctrl_ff.in_range) begin
         if (cfg.dense_mode) begin
            res_value = dense_value;
         end else begin
            res_value = rd_data;
            res_nil   = cfg.check_nils && (rd_data == cfg.value_nil_code);
         end
      end else if (s1_ctrl_ff.id_nil) begin
         res_value = cfg.value_nil_code;
         res_nil   = 1'b1;
      end else begin
         res_miss = 1'b1;
      end
      res_sticky = nil_seen_ff || res_nil;
   end

   // Next state: a restart accepted now is later than the lookup in flight
   always_comb begin
      s1_valid_in  = issue || (s1_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      nil_seen_in  = nil_seen_ff;
      if (advance) begin
         nil_seen_in = res_sticky;
      end
      if (restart) begin
         nil_seen_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         nil_seen_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         nil_seen_ff  <= nil_seen_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ctrl_ff   <= issue_ctrl;
         s1_offset_ff <= issue_offset;
      end
      if (advance) begin
         out_value_ff <= res_value;
         out_flags_ff <= {res_sticky, res_miss, res_nil};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_flags  = out_flags_ff;

endmodule

FILE: dv/indexed_column_gather_unit_tb.sv
module indexed_column_gather_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import icg_pkg::*;

   localparam int DEPTH = ICG_TABLE_DEPTH;

   typedef struct packed {
      logic [31:0] value;
      logic        is_nil;
      logic        no_match;
      logic        has_nil;
   } gather_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // tdata: load_position[9:0], load_value[41:10], row_id[73:42], zero[79:74]
   logic [79:0] req_tdata = '0;
   // tuser: operation[1:0]
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // tdata: value[31:0]
   logic [31:0] rsp_tdata;
   // tuser: value_is_nil[0], no_match[1], column_has_nil[2]
   logic [2:0]  rsp_tuser;

   // Shadow copy of the block: table, sticky flag and settings
   logic [31:0] table_copy [DEPTH];
   bit          slot_loaded [DEPTH];
   bit          nil_sticky = 1'b0;
   logic [31:0] cfg_base = '0;
   logic [10:0] cfg_count = '0;
   bit          cfg_dense = 1'b0;
   logic [31:0] cfg_dense_start = '0;
   bit          cfg_check_nils = 1'b1;
   logic [31:0] cfg_value_nil = 32'h8000_0000;
   logic [31:0] cfg_index_nil = 32'h8000_0000;

   gather_result_type expected_gathers [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_cycles = 0;
   int mismatch_count = 0;

   indexed_column_gather_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response side: a long hold-off first, else random stalls
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 40)
         $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Saturate the entry count at the table depth
   function automatic logic [10:0] count_limit();
      return (cfg_count > 11'(DEPTH)) ? 11'(DEPTH) : cfg_count;
   endfunction

   // Range test without wrap-around
   function automatic bit in_window(logic [31:0] id, output logic [31:0] offset);
      offset = id - cfg_base;
      return (id >= cfg_base) && (offset < 32'(count_limit()));
   endfunction

   // Update the shadow state for one accepted transaction, queue any result
   task automatic gather_expected(icg_op_type op, logic [9:0] pos, logic [31:0] lval,
                                  logic [31:0] id);
      gather_result_type r;
      logic [31:0]       offset;
      r = '0;
      case (op)
         OP_LOAD: begin
            table_copy[pos] = lval;
            slot_loaded[pos] = 1'b1;
         end
         OP_RESTART: nil_sticky = 1'b0;
         OP_PROJECT: begin
            if (in_window(id, offset)) begin
               if (cfg_dense) begin
                  r.value = offset + cfg_dense_start;
               end else begin
                  r.value = table_copy[offset[9:0]];
                  r.is_nil = cfg_check_nils && (r.value == cfg_value_nil);
               end
            end else if (id == cfg_index_nil) begin
               r.value = cfg_value_nil;
               r.is_nil = 1'b1;
            end else begin
               r.no_match = 1'b1;
            end
            if (r.is_nil)
               nil_sticky = 1'b1;
            r.has_nil = nil_sticky;
            expected_gathers.push_back(r);
         end
         default: ;
      endcase
   endtask

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      gather_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_gathers.size() == 0) begin
            report_mismatch("unexpected result, value", rsp_tdata, '0);
         end else begin
            want = expected_gathers.pop_front();
            if (rsp_tdata !== want.value)
               report_mismatch("value", rsp_tdata, want.value);
            if (rsp_tuser[0] !== want.is_nil)
               report_mismatch("value_is_nil", 32'(rsp_tuser[0]), 32'(want.is_nil));
            if (rsp_tuser[1] !== want.no_match)
               report_mismatch("no_match", 32'(rsp_tuser[1]), 32'(want.no_match));
            if (rsp_tuser[2] !== want.has_nil)
               report_mismatch("column_has_nil", 32'(rsp_tuser[2]), 32'(want.has_nil));
         end
      end
   end

   // Offer one request transaction and hold it until accepted
   task automatic send_item(icg_op_type op, logic [9:0] pos, logic [31:0] lval,
                            logic [31:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, id, lval, pos};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      gather_expected(op, pos, lval, id);
   endtask

   // Drop valid, wait for every result, then let loads settle
   task automatic finish_phase();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_gathers.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(icg_csr_type idx, logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all registers; only called while the block is idle
   task automatic program_setup(logic [31:0] base, logic [10:0] cnt, bit dense,
                                logic [31:0] dstart, bit chk, logic [31:0] vnil,
                                logic [31:0] inil);
      cfg_base = base;
      cfg_count = cnt;
      cfg_dense = dense;
      cfg_dense_start = dstart;
      cfg_check_nils = chk;
      cfg_value_nil = vnil;
      cfg_index_nil = inil;
      csr_write(CSR_RIGHT_BASE, base);
      csr_write(CSR_RIGHT_COUNT, 32'(cnt));
      csr_write(CSR_DENSE_MODE, 32'(dense));
      csr_write(CSR_DENSE_START, dstart);
      csr_write(CSR_CHECK_NILS, 32'(chk));
      csr_write(CSR_VALUE_NIL_CODE, vnil);
      csr_write(CSR_INDEX_NIL_CODE, inil);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_setup();
      logic [31:0] base, dstart, vnil, inil;
      logic [10:0] cnt;
      int          n;
      n = $urandom_range(99);
      if (n < 5)       cnt = 11'd0;
      else if (n < 10) cnt = 11'd1;
      else if (n < 25) cnt = 11'd1024;
      else if (n < 30) cnt = 11'd2047;
      else if (n < 35) cnt = 11'($urandom_range(1025, 2046));
      else             cnt = 11'($urandom_range(2, 200));
      n = $urandom_range(99);
      if (n < 15)      base = '0;
      else if (n < 30) base = 32'hFFFF_FFFF - $urandom_range(1100);
      else             base = $urandom;
      n = $urandom_range(99);
      if (n < 20)      dstart = 32'hFFFF_FFFF - $urandom_range(300);
      else if (n < 35) dstart = '0;
      else             dstart = $urandom;
      n = $urandom_range(99);
      if (n < 30)      vnil = 32'h8000_0000;
      else if (n < 40) vnil = '0;
      else if (n < 50) vnil = '1;
      else             vnil = $urandom;
      n = $urandom_range(99);
      if (n < 25)      inil = 32'h8000_0000;
      else if (n < 45) inil = base + $urandom_range(cnt);
      else if (n < 55) inil = '1;
      else if (n < 65) inil = '0;
      else             inil = $urandom;
      program_setup(base, cnt, ($urandom_range(3) == 0), dstart, ($urandom_range(3) != 0),
                    vnil, inil);
   endtask

   function automatic logic [31:0] pick_load_value();
      int n;
      n = $urandom_range(99);
      if (n < 15) return cfg_value_nil;
      if (n < 20) return '0;
      if (n < 25) return '1;
      return $urandom;
   endfunction

   // Mostly lookups, plus loads, restarts and noise
   task automatic send_random_item(output bit counted);
      icg_op_type  op;
      logic [9:0]  pos;
      logic [31:0] lval, id, offset;
      logic [10:0] lim;
      int          pick, n;
      lim = count_limit();
      pos = 10'($urandom);
      lval = $urandom;
      id = $urandom;
      counted = 1'b1;
      pick = $urandom_range(99);
      if (pick < 20) begin
         op = OP_LOAD;
         if (lim != 0 && $urandom_range(3) != 0)
            pos = 10'($urandom_range(lim - 1));
         lval = pick_load_value();
      end else if (pick < 25) begin
         op = OP_RESTART;
      end else if (pick < 27) begin
         op = OP_NONE;
         counted = 1'b0;
      end else begin
         op = OP_PROJECT;
         n = $urandom_range(99);
         if (n < 45 && lim != 0) id = cfg_base + $urandom_range(lim - 1);
         else if (n < 60)        id = cfg_index_nil;
         else if (n < 70)        id = cfg_base - 1;
         else if (n < 80)        id = cfg_base + lim;
         // never fetch a slot that holds no value yet: load it instead
         if (!cfg_dense && in_window(id, offset) && !slot_loaded[offset[9:0]]) begin
            op = OP_LOAD;
            pos = offset[9:0];
            lval = pick_load_value();
         end
      end
      send_item(op, pos, lval, id);
   endtask

   task automatic run_traffic(int items, int sender_idle, int receiver_stall);
      int sent;
      bit counted;
      send_idle_pct = sender_idle;
      rsp_stall_pct = receiver_stall;
      for (int s = 0; s < 4; s++) begin
         random_setup();
         sent = 0;
         while (sent < items / 4) begin
            send_random_item(counted);
            if (counted)
               sent++;
         end
         finish_phase();
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // reset settings: empty window, default nil codes
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'h8000_0000);
      send_item(OP_PROJECT, 10'h3FF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(OP_RESTART, 10'd0, 32'd0, 32'd0);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'hFFFF_FFFF);
      send_item(OP_NONE, 10'h3FF, 32'hFFFF_FFFF, 32'h8000_0000);
      send_item(OP_LOAD, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      finish_phase();
      // window at the top of the id space, all-ones nil value
      program_setup(32'hFFFF_FFFC, 11'd4, 1'b0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_LOAD, 10'd0, 32'h0000_0000, 32'd0);
      send_item(OP_LOAD, 10'd1, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_LOAD, 10'd2, 32'h1234_5678, 32'd0);
      send_item(OP_LOAD, 10'd3, 32'h8000_0000, 32'd0);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'hFFFF_FFFC);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'hFFFF_FFFD);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'hFFFF_FFFF);
      // below the base: nil id first, then a plain miss
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'h0000_0000);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'h0000_0001);
      send_item(OP_RESTART, 10'd0, 32'd0, 32'd0);
      finish_phase();
      // dense sequence wrapping past all-ones, oversized count, nil id in range
      program_setup(32'd0, 11'd2047, 1'b1, 32'hFFFF_FFFE, 1'b0, 32'hFFFF_FFFF, 32'd5);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'd0);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'd1);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'd2);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'd5);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'd1023);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'd1024);
      finish_phase();
      // stored nil pattern with the nil check off
      program_setup(32'hFFFF_FFFC, 11'd4, 1'b0, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_PROJECT, 10'd0, 32'd0, 32'hFFFF_FFFD);
      finish_phase();
   endtask

   task automatic test_slow_receiver();
      run_traffic(540, 9, 81);
   endtask

   task automatic test_slow_sender();
      run_traffic(540, 81, 9);
   endtask

   task automatic test_full_rate();
      run_traffic(540, 0, 0);
   endtask

   // Hold the response side off so the pipeline fills and stalls requests
   task automatic test_input_stall();
      logic [31:0] base;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      base = $urandom;
      program_setup(base, 11'd1024, 1'b1, $urandom, 1'b1, 32'h8000_0000, 32'h8000_0000);
      @(posedge clock);
      rsp_hold_cycles = 120;
      for (int i = 0; i < 64; i++)
         send_item(OP_PROJECT, 10'($urandom), $urandom, base + $urandom_range(1100));
      finish_phase();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_slow_receiver();
      test_slow_sender();
      test_full_rate();
      test_input_stall();
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
